@@ hw/rtl/xor_convolution_engine_core_macros.svh @@
// Assertion macros shared by the XOR convolution engine RTL.
// Included by the top level; expects i_clk and i_rst_n in the including module.
`ifndef XOR_CONVOLUTION_ENGINE_CORE_MACROS_SVH
`define XOR_CONVOLUTION_ENGINE_CORE_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low.
`define XCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is low.
`define XCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/xce_pkg.sv @@
// Package for the XOR convolution engine: sizes, the write-select code and the
// control bundle passed from the sequencer to the datapath. No dependencies.
`timescale 1ns / 1ps

package xce_pkg;

    localparam int MAX_LOG    = 6;
    localparam int ELEM_WIDTH = 16;

    localparam int DEPTH  = 1 << MAX_LOG;
    localparam int ADDR_W = MAX_LOG;
    localparam int CNT_W  = MAX_LOG + 1;
    localparam int LG_W   = $clog2(MAX_LOG + 1);

    // Register and port field widths.
    localparam int CFG_W       = 3;
    localparam int IN_FIELD_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int C_W         = 38;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_W-1:0] LOG_SIZE_RESET = 3'd6;

    // Forward transform values fit MUL_W signed bits; products and the inverse
    // transform fit DATA_W bits, which is never narrower than the output field.
    localparam int MUL_W    = ELEM_WIDTH + MAX_LOG;
    localparam int DATA_MIN = 2 * MUL_W + 4;
    localparam int DATA_W   = (DATA_MIN > C_W) ? DATA_MIN : C_W;

    typedef enum logic [1:0] {
        WSEL_LOAD,
        WSEL_SUM,
        WSEL_DIFF,
        WSEL_PROD
    } t_wsel;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_p;
        logic [ADDR_W-1:0] rd_q;
        logic              we_a;
        logic              we_b;
        logic [ADDR_W-1:0] wr_addr;
        t_wsel             wsel;
        logic              inv;
        logic              out_load;
    } t_ctrl;

endpackage

@@ hw/rtl/xce_bfly.sv @@
// Walsh-Hadamard butterfly: sum and difference, halved toward zero when inverse.
// Depends on xce_pkg.
`timescale 1ns / 1ps

module xce_bfly (
    input  logic [xce_pkg::DATA_W-1:0] i_u,
    input  logic [xce_pkg::DATA_W-1:0] i_v,
    input  logic                       i_inv,
    output logic [xce_pkg::DATA_W-1:0] o_sum,
    output logic [xce_pkg::DATA_W-1:0] o_diff
);

    localparam int W = xce_pkg::DATA_W;

    logic [W:0] sum;
    logic [W:0] diff;
    logic [W:0] sum_adj;
    logic [W:0] diff_adj;

    assign sum  = {i_u[W-1], i_u} + {i_v[W-1], i_v};
    assign diff = {i_u[W-1], i_u} - {i_v[W-1], i_v};

    // Adding the sign bit before the arithmetic shift rounds toward zero.
    assign sum_adj  = sum  + {{W{1'b0}}, sum[W]};
    assign diff_adj = diff + {{W{1'b0}}, diff[W]};

    assign o_sum  = i_inv ? sum_adj[W:1]  : sum[W-1:0];
    assign o_diff = i_inv ? diff_adj[W:1] : diff[W-1:0];

endmodule

@@ hw/rtl/xce_ctrl.sv @@
// Sequencer of the XOR convolution engine: load, forward transforms, pointwise
// product, inverse transform and result output. Depends on xce_pkg.
`timescale 1ns / 1ps

module xce_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [xce_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_cfg_ready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output logic                      o_out_last,
    input  logic                      i_out_ready,
    output xce_pkg::t_ctrl            o_ctrl
);

    localparam int AW = xce_pkg::ADDR_W;
    localparam int CW = xce_pkg::CNT_W;
    localparam int LW = xce_pkg::LG_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_CALC,
        ST_BF_DRAIN,
        ST_MUL,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

    t_state                    r_state;
    logic [xce_pkg::CFG_W-1:0] r_log;
    logic [CW-1:0]             r_cnt;
    logic [LW-1:0]             r_stage;
    logic [AW-1:0]             r_k;
    logic [AW-1:0]             r_qaddr;
    logic [CW-1:0]             r_idx;
    logic                      r_inv;
    logic                      r_out_valid;
    logic                      r_out_last;

    logic [LW-1:0] lg;
    logic [CW-1:0] n_items;
    logic [CW-1:0] n_m1;
    logic [CW-1:0] n_p1;
    logic [AW-1:0] k_last;
    logic [AW-1:0] half;
    logic [AW-1:0] lowmask;
    logic [AW-1:0] bf_p;
    logic [AW-1:0] bf_q;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] idx_m2;
    logic          in_take;

    // Sizes above the maximum run at the maximum.
    assign lg      = (32'(r_log) > xce_pkg::MAX_LOG) ? LW'(xce_pkg::MAX_LOG) : LW'(r_log);
    assign n_items = CW'(1) << lg;
    assign n_m1    = n_items - CW'(1);
    assign n_p1    = n_items + CW'(1);
    assign k_last  = AW'((n_items >> 1) - CW'(1));

    // Butterfly k of a stage pairs entries that differ only in bit 'stage'.
    assign half    = AW'(1) << r_stage;
    assign lowmask = half - AW'(1);
    assign bf_p    = ((r_k & ~lowmask) << 1) | (r_k & lowmask);
    assign bf_q    = bf_p | half;

    assign idx_next = r_idx + CW'(1);
    assign idx_m2   = r_idx - CW'(2);

    assign o_cfg_ready = (r_state == ST_LOAD);
    assign o_in_ready  = (r_state == ST_LOAD) && !i_cfg_valid;
    assign in_take     = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;

    always_comb begin
        o_ctrl.rd_p     = bf_p;
        o_ctrl.rd_q     = bf_q;
        o_ctrl.we_a     = 1'b0;
        o_ctrl.we_b     = 1'b0;
        o_ctrl.wr_addr  = bf_p;
        o_ctrl.wsel     = xce_pkg::WSEL_SUM;
        o_ctrl.inv      = r_inv;
        o_ctrl.out_load = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_ctrl.we_a    = in_take;
                o_ctrl.we_b    = in_take;
                o_ctrl.wr_addr = r_cnt[AW-1:0];
                o_ctrl.wsel    = xce_pkg::WSEL_LOAD;
            end
            ST_BF_RD: begin
                // The previous butterfly's difference goes back while the next pair is read.
                if (r_k != '0) begin
                    o_ctrl.we_a    = 1'b1;
                    o_ctrl.we_b    = !r_inv;
                    o_ctrl.wr_addr = r_qaddr;
                    o_ctrl.wsel    = xce_pkg::WSEL_DIFF;
                end
            end
            ST_BF_CALC: begin
                o_ctrl.we_a    = 1'b1;
                o_ctrl.we_b    = !r_inv;
                o_ctrl.wr_addr = bf_p;
                o_ctrl.wsel    = xce_pkg::WSEL_SUM;
            end
            ST_BF_DRAIN: begin
                o_ctrl.we_a    = 1'b1;
                o_ctrl.we_b    = !r_inv;
                o_ctrl.wr_addr = r_qaddr;
                o_ctrl.wsel    = xce_pkg::WSEL_DIFF;
            end
            ST_MUL: begin
                o_ctrl.rd_p    = r_idx[AW-1:0];
                o_ctrl.we_a    = (r_idx >= CW'(2));
                o_ctrl.wr_addr = idx_m2[AW-1:0];
                o_ctrl.wsel    = xce_pkg::WSEL_PROD;
            end
            ST_OUT_RD: begin
                o_ctrl.rd_p = r_idx[AW-1:0];
            end
            ST_OUT_LD: begin
                o_ctrl.out_load = 1'b1;
            end
            ST_OUT_WAIT: begin
                o_ctrl.rd_p = idx_next[AW-1:0];
            end
            default: begin
                o_ctrl.we_a = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_log       <= xce_pkg::LOG_SIZE_RESET;
            r_cnt       <= '0;
            r_stage     <= '0;
            r_k         <= '0;
            r_qaddr     <= '0;
            r_idx       <= '0;
            r_inv       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (i_cfg_valid) begin
                        r_log <= i_cfg_data;
                        r_cnt <= '0;
                    end else if (i_in_valid) begin
                        if (r_cnt == n_m1) begin
                            r_cnt   <= '0;
                            r_stage <= '0;
                            r_k     <= '0;
                            r_idx   <= '0;
                            r_inv   <= 1'b0;
                            r_state <= (lg == '0) ? ST_MUL : ST_BF_RD;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                ST_BF_RD: begin
                    r_state <= ST_BF_CALC;
                end
                ST_BF_CALC: begin
                    r_qaddr <= bf_q;
                    if (r_k == k_last) begin
                        r_k     <= '0;
                        r_state <= ST_BF_DRAIN;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= ST_BF_RD;
                    end
                end
                ST_BF_DRAIN: begin
                    if (r_stage == lg - LW'(1)) begin
                        r_stage <= '0;
                        r_idx   <= '0;
                        r_state <= r_inv ? ST_OUT_RD : ST_MUL;
                    end else begin
                        r_stage <= r_stage + LW'(1);
                        r_state <= ST_BF_RD;
                    end
                end
                ST_MUL: begin
                    if (r_idx == n_p1) begin
                        r_idx   <= '0;
                        r_inv   <= 1'b1;
                        r_state <= (lg == '0) ? ST_OUT_RD : ST_BF_RD;
                    end else begin
                        r_idx <= idx_next;
                    end
                end
                ST_OUT_RD: begin
                    r_state <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_last  <= (r_idx == n_m1);
                    r_state     <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_idx   <= idx_next;
                            r_state <= ST_OUT_LD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/xce_datapath.sv @@
// Datapath of the XOR convolution engine: the two vector memories, the butterfly
// units, the multiplier and the result register. Depends on xce_pkg, xce_bfly.
`timescale 1ns / 1ps

module xce_datapath (
    input  logic                           i_clk,
    input  xce_pkg::t_ctrl                 i_ctrl,
    input  logic [xce_pkg::IN_FIELD_W-1:0] i_a_value,
    input  logic [xce_pkg::IN_FIELD_W-1:0] i_b_value,
    output logic [xce_pkg::C_W-1:0]        o_c_value
);

    localparam int W  = xce_pkg::DATA_W;
    localparam int EW = xce_pkg::ELEM_WIDTH;
    localparam int MW = xce_pkg::MUL_W;

    logic [W-1:0] r_mem_a [xce_pkg::DEPTH];
    logic [W-1:0] r_mem_b [xce_pkg::DEPTH];

    logic [W-1:0] r_a_p;
    logic [W-1:0] r_a_q;
    logic [W-1:0] r_b_p;
    logic [W-1:0] r_b_q;
    logic [W-1:0] r_diff_a;
    logic [W-1:0] r_diff_b;
    logic [W-1:0] r_prod;
    logic [xce_pkg::C_W-1:0] r_c;

    logic [W-1:0] sum_a;
    logic [W-1:0] diff_a;
    logic [W-1:0] sum_b;
    logic [W-1:0] diff_b;
    logic [W-1:0] load_a;
    logic [W-1:0] load_b;
    logic [W-1:0] wdata_a;
    logic [W-1:0] wdata_b;

    logic signed [MW-1:0]   mul_x;
    logic signed [MW-1:0]   mul_y;
    logic signed [2*MW-1:0] mul_z;

    xce_bfly u_bfly_a (
        .i_u    (r_a_p),
        .i_v    (r_a_q),
        .i_inv  (i_ctrl.inv),
        .o_sum  (sum_a),
        .o_diff (diff_a)
    );

    xce_bfly u_bfly_b (
        .i_u    (r_b_p),
        .i_v    (r_b_q),
        .i_inv  (i_ctrl.inv),
        .o_sum  (sum_b),
        .o_diff (diff_b)
    );

    assign load_a = {{(W-EW){i_a_value[EW-1]}}, i_a_value[EW-1:0]};
    assign load_b = {{(W-EW){i_b_value[EW-1]}}, i_b_value[EW-1:0]};

    // Transformed values fit MUL_W signed bits, so only those feed the multiplier.
    assign mul_x = r_a_p[MW-1:0];
    assign mul_y = r_b_p[MW-1:0];
    assign mul_z = mul_x * mul_y;

    always_comb begin
        unique case (i_ctrl.wsel)
            xce_pkg::WSEL_LOAD: begin
                wdata_a = load_a;
                wdata_b = load_b;
            end
            xce_pkg::WSEL_SUM: begin
                wdata_a = sum_a;
                wdata_b = sum_b;
            end
            xce_pkg::WSEL_DIFF: begin
                wdata_a = r_diff_a;
                wdata_b = r_diff_b;
            end
            xce_pkg::WSEL_PROD: begin
                wdata_a = r_prod;
                wdata_b = r_prod;
            end
            default: begin
                wdata_a = load_a;
                wdata_b = load_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_a) begin
            r_mem_a[i_ctrl.wr_addr] <= wdata_a;
        end
        r_a_p <= r_mem_a[i_ctrl.rd_p];
        r_a_q <= r_mem_a[i_ctrl.rd_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_b) begin
            r_mem_b[i_ctrl.wr_addr] <= wdata_b;
        end
        r_b_p <= r_mem_b[i_ctrl.rd_p];
        r_b_q <= r_mem_b[i_ctrl.rd_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wsel == xce_pkg::WSEL_SUM) begin
            r_diff_a <= diff_a;
            r_diff_b <= diff_b;
        end
        r_prod <= {{(W-2*MW){mul_z[2*MW-1]}}, mul_z};
        if (i_ctrl.out_load) begin
            r_c <= r_a_p[xce_pkg::C_W-1:0];
        end
    end

    assign o_c_value = r_c;

endmodule

@@ hw/rtl/xor_convolution_engine_core.sv @@
// XOR convolution engine (Walsh-Hadamard) top level.
// Depends on xce_pkg, xce_ctrl, xce_datapath and the shared assertion macros.
// Usage:
//   The slave stream takes one pair per transaction: s_axis_tdata carries a_value in
//   [15:0] and b_value in [31:16]. After n = 2^log_size pairs (log_size above 6 runs
//   as 6), the block computes the XOR convolution and returns n results on the
//   master stream, c_value in m_axis_tdata[37:0], with m_axis_tlast on the last one.
//   The configuration channel writes log_size; a write also restarts loading at
//   index zero. It is taken only while the block is loading.
// Sequence:
//   Loading takes a pair whenever s_axis_tvalid is high and no configuration
//   write is offered. Both forward transforms share one pass of lg stages, since
//   each butterfly writes its two results through the single write port of each
//   memory. The product pass is followed by the inverse transform and the output
//   of the results in order.
// Reset and stalls:
//   Reset (synchronous, active low) returns to loading with log_size 6 and an empty
//   load count. Memory contents are not cleared; every entry is written before use.
//   A stalled receiver holds the current result steady; no new pair is taken until
//   the last result of the run has been accepted.
`timescale 1ns / 1ps
`include "xor_convolution_engine_core_macros.svh"

module xor_convolution_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: log_size.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [xce_pkg::CFG_W-1:0]       i_cfg_data,
    // Input pairs.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [xce_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // a_value, b_value
    // Results.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [xce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // c_value, zero pad
    output logic                            m_axis_tlast
);

    localparam int FW = xce_pkg::IN_FIELD_W;

    xce_pkg::t_ctrl          ctrl;
    logic [xce_pkg::C_W-1:0] c_value;
    logic                    last_taken;

    // Sequencer: owns the handshakes and drives memory addresses and write selects.
    xce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_ctrl      (ctrl)
    );

    // Datapath: both vectors live in memories and are rewritten in place.
    xce_datapath u_datapath (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_a_value (s_axis_tdata[FW-1:0]),
        .i_b_value (s_axis_tdata[2*FW-1:FW]),
        .o_c_value (c_value)
    );

    assign m_axis_tdata = {{(xce_pkg::OUT_TDATA_W - xce_pkg::C_W){1'b0}}, c_value};

    // The last result of a run is taken by the receiver in this cycle.
    assign last_taken = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    // A pair is never taken while a result of the run is still pending.
    `XCE_ASSERT_SAME(a_no_load_during_output, m_axis_tvalid, !s_axis_tready, "load in output")
    // Configuration is only offered while no result is shown.
    `XCE_ASSERT_SAME(a_cfg_only_when_idle, o_cfg_ready, !m_axis_tvalid, "cfg in output")
    // Delivering the last result of a run returns the block to loading.
    `XCE_ASSERT_NEXT(a_last_to_load, last_taken, o_cfg_ready && !m_axis_tvalid, "not back to load")

endmodule
